FILE: hw/rtl/ocpr_pkg.sv
// types and constants shared by the oled command and pixel ram core
package ocpr_pkg;

    // width of the panel column offset register
    localparam int OFFSET_W = 7;

    // action codes of an input beat
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_FRAME = 2'd3;

    // addressing modes
    localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
    localparam logic [1:0] MODE_PAGE       = 2'd2;

    // commands that are decoded
    localparam logic [7:0] CMD_ADDR_MODE = 8'h20;
    localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_DISP_OFF  = 8'hAE;
    localparam logic [7:0] CMD_DISP_ON   = 8'hAF;
    localparam logic [7:0] CMD_PAGE_LO   = 8'hB0;
    localparam logic [7:0] CMD_PAGE_HI   = 8'hB7;
    localparam logic [7:0] CMD_COL_LO_HI = 8'h0F;
    localparam logic [7:0] CMD_COL_HI_LO = 8'h10;
    localparam logic [7:0] CMD_COL_HI_HI = 8'h1F;

    // one-argument commands whose argument is swallowed
    localparam logic [7:0] CMD_CONTRAST  = 8'h81;
    localparam logic [7:0] CMD_CHARGE    = 8'h8D;
    localparam logic [7:0] CMD_MUX_RATIO = 8'hA8;
    localparam logic [7:0] CMD_DISP_OFS  = 8'hD3;
    localparam logic [7:0] CMD_CLK_DIV   = 8'hD5;
    localparam logic [7:0] CMD_PRECHARGE = 8'hD9;
    localparam logic [7:0] CMD_COM_PINS  = 8'hDA;
    localparam logic [7:0] CMD_VCOM_DSEL = 8'hDB;

    // reset values of the window registers
    localparam logic [7:0] WIN_COL_END_RST  = 8'd127;
    localparam logic [7:0] WIN_PAGE_END_RST = 8'd7;

    // input beat
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } ocpr_in_t;

    // result beat
    typedef struct packed {
        logic [7:0] read_data;
        logic       display_on;
        logic       frame_dirty;
    } ocpr_out_t;

endpackage

FILE: hw/rtl/oled_command_and_pixel_ram_core.sv
// oled controller front end: command decoder, address pointers and pixel ram
//
// s_ channel takes one beat per bus event: transfer start, bus byte, pixel
// read or frame taken. m_ channel returns one result beat per input beat, in
// order: the pixel byte for a read, the display on flag and the dirty flag as
// it was before the beat. cfg_ channel writes the panel column offset; it is
// always ready and is meant to be written while the core is idle.
// An accepted beat is held in the input register, then moves into the result
// register, which drives m_valid. Throughput is one beat per cycle while the
// result side does not stall, set by the single read-modify pass over the
// pointers and one write plus one registered read per cycle on the pixel ram.
// After reset the pixel ram is swept to zero, one byte per cycle, over all
// PAGES * 2**clog2(COLUMNS) bytes (1024 at the defaults); s_ready stays low
// during the sweep. When m_ready is low the result is held, one more beat is
// taken into the input register if it is empty, then s_ready drops until the result leaves.
module oled_command_and_pixel_ram_core #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ocpr_pkg::ocpr_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ocpr_pkg::ocpr_out_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ocpr_pkg::OFFSET_W-1:0]  cfg_data
);
    import ocpr_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DEPTH = PAGES * (2 ** COL_W);
    localparam int AW    = $clog2(DEPTH);

    // pixel ram
    logic [7:0] pix_mem [0:DEPTH-1];

    // pipeline registers
    logic        a_valid_reg;
    ocpr_in_t    a_item_reg;
    logic        b_valid_reg;
    logic        b_rd_ok_reg;
    logic        b_disp_reg;
    logic        b_dirty_reg;
    logic [7:0]  mem_q_reg;

    // clearing sweep
    logic          clr_active_reg;
    logic [AW-1:0] clr_cnt_reg;

    // controller state
    logic [OFFSET_W-1:0] offset_reg;
    logic [7:0] col_ptr_reg,        col_ptr_next;
    logic [7:0] page_ptr_reg,       page_ptr_next;
    logic [7:0] win_col_start_reg,  win_col_start_next;
    logic [7:0] win_col_end_reg,    win_col_end_next;
    logic [7:0] win_page_start_reg, win_page_start_next;
    logic [7:0] win_page_end_reg,   win_page_end_next;
    logic [1:0] mode_reg,           mode_next;
    logic [1:0] args_owed_reg,      args_owed_next;
    logic [7:0] pending_reg,        pending_next;
    logic       ctrl_seen_reg,      ctrl_seen_next;
    logic       data_mode_reg,      data_mode_next;
    logic       panel_on_reg,       panel_on_next;
    logic       dirty_reg,          dirty_next;

    logic          advance;
    logic          a_fire;
    logic          wr_en;
    logic          rd_ok;
    logic [8:0]    col_diff;
    logic          col_in;
    logic          page_in;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [PG_W+COL_W-1:0] wfull;
    logic [PG_W+COL_W-1:0] rfull;
    logic [7:0]    col_inc;
    logic [7:0]    page_inc;
    logic [7:0]    col_end_sel;
    logic [7:0]    page_end_sel;
    logic [8:0]    col_limit;
    logic [7:0]    cbyte;

    // handshake
    assign advance   = !b_valid_reg || m_ready;
    assign a_fire    = a_valid_reg && advance;
    assign s_ready   = !clr_active_reg && (!a_valid_reg || advance);
    assign cfg_ready = 1'b1;
    assign m_valid   = b_valid_reg;
    assign cbyte     = a_item_reg.data_byte;

    // write address: current pointers shifted by the panel offset
    assign col_diff = {1'b0, col_ptr_reg} - {2'b00, offset_reg};
    assign col_in   = !col_diff[8] && (col_diff[7:0] < 8'(COLUMNS));
    assign page_in  = page_ptr_reg < 8'(PAGES);
    assign wfull    = {page_ptr_reg[PG_W-1:0], col_diff[COL_W-1:0]};
    assign waddr    = wfull[AW-1:0];

    // read address
    assign rfull = {a_item_reg.read_page[PG_W-1:0], a_item_reg.read_column[COL_W-1:0]};
    assign raddr = rfull[AW-1:0];

    // horizontal mode wrap terms
    assign col_inc      = col_ptr_reg + 8'd1;
    assign page_inc     = page_ptr_reg + 8'd1;
    assign col_end_sel  = (win_col_end_reg != 8'd0) ? win_col_end_reg : 8'(COLUMNS - 1);
    assign page_end_sel = (win_page_end_reg != 8'd0) ? win_page_end_reg : 8'(PAGES - 1);
    assign col_limit    = {1'b0, col_end_sel} + {2'b00, offset_reg};

    // next state for the beat in the input register
    always_comb begin
        col_ptr_next        = col_ptr_reg;
        page_ptr_next       = page_ptr_reg;
        win_col_start_next  = win_col_start_reg;
        win_col_end_next    = win_col_end_reg;
        win_page_start_next = win_page_start_reg;
        win_page_end_next   = win_page_end_reg;
        mode_next           = mode_reg;
        args_owed_next      = args_owed_reg;
        pending_next        = pending_reg;
        ctrl_seen_next      = ctrl_seen_reg;
        data_mode_next      = data_mode_reg;
        panel_on_next       = panel_on_reg;
        dirty_next          = dirty_reg;
        wr_en               = 1'b0;
        rd_ok               = 1'b0;
        if (a_fire) begin
            unique case (a_item_reg.action)
                ACT_START: begin
                    ctrl_seen_next = 1'b0;
                end
                ACT_BYTE: begin
                    if (!ctrl_seen_reg) begin
                        // control byte picks the mode for the transfer
                        ctrl_seen_next = 1'b1;
                        data_mode_next = cbyte[6];
                    end else if (data_mode_reg) begin
                        // pixel byte
                        wr_en         = page_in && col_in;
                        dirty_next    = 1'b1;
                        col_ptr_next  = col_inc;
                        if (mode_reg == MODE_HORIZONTAL && {1'b0, col_inc} > col_limit) begin
                            col_ptr_next = win_col_start_reg;
                            if (page_inc > page_end_sel) begin
                                page_ptr_next = win_page_start_reg;
                            end else begin
                                page_ptr_next = page_inc;
                            end
                        end
                    end else if (args_owed_reg != 2'd0) begin
                        // command argument
                        args_owed_next = args_owed_reg - 2'd1;
                        if (pending_reg == CMD_COL_ADDR) begin
                            if (args_owed_reg == 2'd2) begin
                                win_col_start_next = cbyte;
                                col_ptr_next       = cbyte;
                            end else begin
                                win_col_end_next = cbyte;
                            end
                        end else if (pending_reg == CMD_PAGE_ADDR) begin
                            if (args_owed_reg == 2'd2) begin
                                win_page_start_next = cbyte;
                                page_ptr_next       = cbyte;
                            end else begin
                                win_page_end_next = cbyte;
                            end
                        end else if (pending_reg == CMD_ADDR_MODE) begin
                            mode_next = cbyte[1:0];
                        end
                    end else begin
                        // command opcode
                        unique case (cbyte)
                            CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE, CMD_MUX_RATIO,
                            CMD_DISP_OFS, CMD_CLK_DIV, CMD_PRECHARGE, CMD_COM_PINS,
                            CMD_VCOM_DSEL: begin
                                pending_next   = cbyte;
                                args_owed_next = 2'd1;
                            end
                            CMD_COL_ADDR, CMD_PAGE_ADDR: begin
                                pending_next   = cbyte;
                                args_owed_next = 2'd2;
                            end
                            CMD_DISP_OFF: begin
                                panel_on_next = 1'b0;
                                dirty_next    = 1'b1;
                            end
                            CMD_DISP_ON: begin
                                panel_on_next = 1'b1;
                                dirty_next    = 1'b1;
                            end
                            default: begin
                                if (cbyte >= CMD_PAGE_LO && cbyte <= CMD_PAGE_HI) begin
                                    page_ptr_next = {5'd0, cbyte[2:0]};
                                end else if (cbyte <= CMD_COL_LO_HI) begin
                                    col_ptr_next = {col_ptr_reg[7:4], cbyte[3:0]};
                                end else if (cbyte >= CMD_COL_HI_LO && cbyte <= CMD_COL_HI_HI) begin
                                    col_ptr_next = {cbyte[3:0], col_ptr_reg[3:0]};
                                end
                            end
                        endcase
                    end
                end
                ACT_READ: begin
                    rd_ok = ({1'b0, a_item_reg.read_page} < 4'(PAGES))
                         && ({1'b0, a_item_reg.read_column} < 8'(COLUMNS));
                end
                ACT_FRAME: begin
                    dirty_next = 1'b0;
                end
            endcase
        end
    end

    // pixel ram: clearing sweep or one write, one registered read
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            pix_mem[clr_cnt_reg] <= 8'd0;
        end else if (wr_en) begin
            pix_mem[waddr] <= cbyte;
        end
        if (a_fire) begin
            mem_q_reg <= pix_mem[raddr];
        end
    end

    // result stage payload
    always_ff @(posedge aclk) begin
        if (a_fire) begin
            b_rd_ok_reg <= rd_ok;
            b_disp_reg  <= panel_on_next;
            b_dirty_reg <= dirty_reg;
        end
        if (s_valid && s_ready) begin
            a_item_reg <= s_data;
        end
    end

    assign m_data.read_data   = b_rd_ok_reg ? mem_q_reg : 8'd0;
    assign m_data.display_on  = b_disp_reg;
    assign m_data.frame_dirty = b_dirty_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg        <= 1'b0;
            b_valid_reg        <= 1'b0;
            clr_active_reg     <= 1'b1;
            clr_cnt_reg        <= '0;
            offset_reg         <= '0;
            col_ptr_reg        <= 8'd0;
            page_ptr_reg       <= 8'd0;
            win_col_start_reg  <= 8'd0;
            win_col_end_reg    <= WIN_COL_END_RST;
            win_page_start_reg <= 8'd0;
            win_page_end_reg   <= WIN_PAGE_END_RST;
            mode_reg           <= MODE_PAGE;
            args_owed_reg      <= 2'd0;
            pending_reg        <= 8'd0;
            ctrl_seen_reg      <= 1'b0;
            data_mode_reg      <= 1'b0;
            panel_on_reg       <= 1'b0;
            dirty_reg          <= 1'b1;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end else if (a_fire) begin
                a_valid_reg <= 1'b0;
            end
            if (advance) begin
                b_valid_reg <= a_valid_reg;
            end
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready) begin
                offset_reg <= cfg_data;
            end
            col_ptr_reg        <= col_ptr_next;
            page_ptr_reg       <= page_ptr_next;
            win_col_start_reg  <= win_col_start_next;
            win_col_end_reg    <= win_col_end_next;
            win_page_start_reg <= win_page_start_next;
            win_page_end_reg   <= win_page_end_next;
            mode_reg           <= mode_next;
            args_owed_reg      <= args_owed_next;
            pending_reg        <= pending_next;
            ctrl_seen_reg      <= ctrl_seen_next;
            data_mode_reg      <= data_mode_next;
            panel_on_reg       <= panel_on_next;
            dirty_reg          <= dirty_next;
        end
    end

    // no beat is held while the ram is being cleared
    a_no_beat_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> (!s_ready && !a_valid_reg))
        else $error("beat present during pixel ram clear");

    // a processed beat always lands in the result stage
    a_fire_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        a_fire |=> b_valid_reg)
        else $error("processed beat lost before result stage");

    // at most two command arguments are ever owed
    a_args_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        args_owed_reg != 2'd3)
        else $error("argument count out of range");

    // frame taken clears the dirty flag
    a_frame_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && a_item_reg.action == ACT_FRAME) |=> !dirty_reg)
        else $error("dirty flag not cleared by frame taken");

    // a pixel byte that is written to the ram always marks the frame dirty
    a_write_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> dirty_reg)
        else $error("pixel write left frame clean");

endmodule

FILE: test/tb_oled_command_and_pixel_ram_core.sv
// testbench for the oled command and pixel ram core: directed and random bus traffic
module tb_oled_command_and_pixel_ram_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ocpr_pkg::*;

    localparam int COLUMNS   = 128;
    localparam int PAGES     = 8;
    localparam int RUN_LIMIT = 500000;

    // control byte bits and a command byte the decoder does not know
    localparam logic [7:0] CTRL_DATA   = 8'h40;
    localparam logic [7:0] CTRL_CO     = 8'h80;
    localparam logic [7:0] CMD_UNKNOWN = 8'hE3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    ocpr_in_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    ocpr_out_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [OFFSET_W-1:0] cfg_data  = '0;

    // panel state as the testbench sees it
    logic [7:0]          pix_mem [PAGES*COLUMNS];
    logic [7:0]          col_ptr     = 8'd0;
    logic [7:0]          page_ptr    = 8'd0;
    logic [7:0]          win_col_lo  = 8'd0;
    logic [7:0]          win_col_hi  = WIN_COL_END_RST;
    logic [7:0]          win_page_lo = 8'd0;
    logic [7:0]          win_page_hi = WIN_PAGE_END_RST;
    logic [1:0]          mode_q      = MODE_PAGE;
    logic [1:0]          args_due    = 2'd0;
    logic [7:0]          cmd_held    = 8'd0;
    logic                ctrl_seen   = 1'b0;
    logic                data_mode_q = 1'b0;
    logic                panel_on_q  = 1'b0;
    logic                dirty_q     = 1'b1;
    logic [OFFSET_W-1:0] col_offset_q = '0;

    ocpr_out_t           readback_q [$];

    int                  beats_sent      = 0;
    int                  results_checked = 0;
    int                  error_count     = 0;
    int                  cycle_count     = 0;
    bit                  src_idle_on     = 1'b1;
    bit                  sink_idle_on    = 1'b1;

    oled_command_and_pixel_ram_core #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("oled_command_and_pixel_ram_core: mismatch");
            $finish;
        end
    end

    // pixel byte write at the current pointers, then pointer advance
    function automatic void store_pixel_byte(input logic [7:0] b);
        int col;
        int col_end;
        int page_last;
        col = int'(col_ptr) - int'(col_offset_q);
        if (int'(page_ptr) < PAGES && col >= 0 && col < COLUMNS) begin
            pix_mem[int'(page_ptr) * COLUMNS + col] = b;
        end
        dirty_q = 1'b1;
        col_ptr = col_ptr + 8'd1;
        // only horizontal mode wraps; a zero window end means the panel edge
        if (mode_q == MODE_HORIZONTAL) begin
            col_end   = (win_col_hi != 8'd0) ? int'(win_col_hi) : COLUMNS - 1;
            page_last = (win_page_hi != 8'd0) ? int'(win_page_hi) : PAGES - 1;
            if (int'(col_ptr) > col_end + int'(col_offset_q)) begin
                col_ptr  = win_col_lo;
                page_ptr = page_ptr + 8'd1;
                if (int'(page_ptr) > page_last) begin
                    page_ptr = win_page_lo;
                end
            end
        end
    endfunction

    // command byte or argument byte
    function automatic void decode_command(input logic [7:0] c);
        if (args_due != 2'd0) begin
            case (cmd_held)
                CMD_COL_ADDR: begin
                    if (args_due == 2'd2) begin
                        win_col_lo = c;
                        col_ptr    = c;
                    end else begin
                        win_col_hi = c;
                    end
                end
                CMD_PAGE_ADDR: begin
                    if (args_due == 2'd2) begin
                        win_page_lo = c;
                        page_ptr    = c;
                    end else begin
                        win_page_hi = c;
                    end
                end
                CMD_ADDR_MODE: mode_q = c[1:0];
                default: ;
            endcase
            args_due = args_due - 2'd1;
        end else begin
            case (c)
                CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE, CMD_MUX_RATIO, CMD_DISP_OFS,
                CMD_CLK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOM_DSEL: begin
                    cmd_held = c;
                    args_due = 2'd1;
                end
                CMD_COL_ADDR, CMD_PAGE_ADDR: begin
                    cmd_held = c;
                    args_due = 2'd2;
                end
                CMD_DISP_OFF: begin
                    panel_on_q = 1'b0;
                    dirty_q    = 1'b1;
                end
                CMD_DISP_ON: begin
                    panel_on_q = 1'b1;
                    dirty_q    = 1'b1;
                end
                default: begin
                    if (c >= CMD_PAGE_LO && c <= CMD_PAGE_HI) begin
                        page_ptr = c - CMD_PAGE_LO;
                    end else if (c <= CMD_COL_LO_HI) begin
                        col_ptr = {col_ptr[7:4], c[3:0]};
                    end else if (c >= CMD_COL_HI_LO && c <= CMD_COL_HI_HI) begin
                        col_ptr = {c[3:0], col_ptr[3:0]};
                    end
                end
            endcase
        end
    endfunction

    // one accepted input beat: update the panel state, queue the result
    function automatic void apply_bus_event(input ocpr_in_t beat);
        ocpr_out_t res;
        res             = '0;
        res.frame_dirty = dirty_q;
        case (beat.action)
            ACT_START: ctrl_seen = 1'b0;
            ACT_BYTE: begin
                if (!ctrl_seen) begin
                    ctrl_seen   = 1'b1;
                    data_mode_q = beat.data_byte[6];
                end else if (data_mode_q) begin
                    store_pixel_byte(beat.data_byte);
                end else begin
                    decode_command(beat.data_byte);
                end
            end
            ACT_READ: begin
                if (int'(beat.read_page) < PAGES && int'(beat.read_column) < COLUMNS) begin
                    res.read_data = pix_mem[int'(beat.read_page) * COLUMNS
                                            + int'(beat.read_column)];
                end
            end
            default: dirty_q = 1'b0;
        endcase
        res.display_on = panel_on_q;
        readback_q.push_back(res);
    endfunction

    // result side: random stalls, compare each beat with the oldest expectation
    initial begin : result_checker
        ocpr_out_t want;
        int        stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (readback_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    error_count++;
                end else begin
                    want = readback_q.pop_front();
                    results_checked++;
                    if (m_data.read_data !== want.read_data) begin
                        $error("read_data expected %0h got %0h", want.read_data,
                               m_data.read_data);
                        error_count++;
                    end
                    if (m_data.display_on !== want.display_on) begin
                        $error("display_on expected %0b got %0b", want.display_on,
                               m_data.display_on);
                        error_count++;
                    end
                    if (m_data.frame_dirty !== want.frame_dirty) begin
                        $error("frame_dirty expected %0b got %0b", want.frame_dirty,
                               m_data.frame_dirty);
                        error_count++;
                    end
                end
                stall = sink_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one beat and wait for it to be taken; valid is left high so
    // the next beat can follow without a gap
    task automatic send_beat(input ocpr_in_t beat);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        apply_bus_event(beat);
        beats_sent++;
    endtask

    // non-read beat with junk in the read fields
    function automatic ocpr_in_t bus_beat(input logic [1:0] act, input logic [7:0] b);
        ocpr_in_t beat;
        beat.action      = act;
        beat.data_byte   = b;
        beat.read_page   = 3'($urandom);
        beat.read_column = 7'($urandom);
        return beat;
    endfunction

    task automatic send_start();
        send_beat(bus_beat(ACT_START, 8'($urandom)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(bus_beat(ACT_BYTE, b));
    endtask

    task automatic send_frame_taken();
        send_beat(bus_beat(ACT_FRAME, 8'($urandom)));
    endtask

    task automatic send_read(input logic [2:0] pg, input logic [6:0] cl);
        ocpr_in_t beat;
        beat.action      = ACT_READ;
        beat.data_byte   = 8'($urandom);
        beat.read_page   = pg;
        beat.read_column = cl;
        send_beat(beat);
    endtask

    // drop valid, wait for every result and the pipeline to empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (readback_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_column_offset(input logic [OFFSET_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        cfg_valid    <= 1'b0;
        col_offset_q = value;
    endtask

    // one command with its arguments
    task automatic send_command_group();
        logic [7:0] swallowed [8];
        swallowed = '{CMD_CONTRAST, CMD_CHARGE, CMD_MUX_RATIO, CMD_DISP_OFS,
                      CMD_CLK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOM_DSEL};
        case ($urandom_range(0, 8))
            0: begin
                send_byte(CMD_ADDR_MODE);
                send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
            end
            1: begin
                send_byte(CMD_COL_ADDR);
                send_byte($urandom_range(0, 3) != 0 ? 8'(col_offset_q + $urandom_range(0, 127))
                                                    : 8'($urandom));
                send_byte($urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom_range(0, 127)));
            end
            2: begin
                send_byte(CMD_PAGE_ADDR);
                send_byte($urandom_range(0, 7) != 0 ? 8'($urandom_range(0, 7)) : 8'($urandom));
                send_byte($urandom_range(0, 7) != 0 ? 8'($urandom_range(0, 7)) : 8'($urandom));
            end
            3: send_byte(CMD_PAGE_LO + 8'($urandom_range(0, 7)));
            4: send_byte(8'($urandom_range(0, 15)));
            5: send_byte(CMD_COL_HI_LO + 8'($urandom_range(0, 15)));
            6: send_byte($urandom_range(0, 1) ? CMD_DISP_ON : CMD_DISP_OFF);
            7: begin
                send_byte(swallowed[$urandom_range(0, 7)]);
                send_byte(8'($urandom));
            end
            default: send_byte(8'($urandom));
        endcase
    endtask

    // mostly well formed transfers with reads, frame takes and junk mixed in
    task automatic run_bus_traffic(input int n_beats);
        int stop_at;
        int kind;
        int len;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 31) == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                // pixel data transfer, Co bit random
                send_start();
                send_byte((8'($urandom) & ~CTRL_DATA) | CTRL_DATA);
                len = $urandom_range(1, 16);
                repeat (len) begin
                    send_byte(8'($urandom));
                    if ($urandom_range(0, 7) == 0) begin
                        send_read(page_ptr[2:0], 7'(col_ptr - col_offset_q - 8'd1));
                    end
                end
            end else if (kind < 13) begin
                send_start();
                send_byte(8'($urandom) & ~CTRL_DATA);
                len = $urandom_range(1, 4);
                repeat (len) send_command_group();
            end else if (kind < 16) begin
                if ($urandom_range(0, 1) != 0) begin
                    send_read(page_ptr[2:0],
                              7'(col_ptr - col_offset_q - 8'($urandom_range(1, 4))));
                end else begin
                    send_read(3'($urandom), 7'($urandom));
                end
            end else if (kind < 17) begin
                send_frame_taken();
            end else begin
                send_beat(ocpr_in_t'(20'($urandom)));
            end
        end
    endtask

    // fresh store reads zero, dirty starts set
    task automatic test_power_up();
        send_frame_taken();
        send_read(3'd0, 7'd0);
        send_read(3'd7, 7'd127);
    endtask

    // display on and off, swallowed argument, unknown command
    task automatic test_display_commands();
        send_start();
        send_byte(8'h00);
        send_byte(CMD_DISP_ON);
        send_byte(CMD_CONTRAST);
        send_byte(CMD_DISP_OFF);
        send_byte(CMD_UNKNOWN);
    endtask

    // horizontal mode in a two-column, two-page window wraps column and page
    task automatic test_horizontal_wrap();
        send_start();
        send_byte(8'h00);
        send_byte(CMD_ADDR_MODE);
        send_byte({6'd0, MODE_HORIZONTAL});
        send_byte(CMD_COL_ADDR);
        send_byte(8'd126);
        send_byte(8'd127);
        send_byte(CMD_PAGE_ADDR);
        send_byte(8'd6);
        send_byte(8'd7);
        send_start();
        send_byte(CTRL_CO | CTRL_DATA);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'h18);
        send_byte(8'h5A);
        send_read(3'd6, 7'd126);
        send_read(3'd6, 7'd127);
        send_read(3'd7, 7'd127);
        send_frame_taken();
    endtask

    // random traffic under several column offsets, extremes included
    task automatic test_offset_phases();
        logic [OFFSET_W-1:0] offsets [5];
        offsets = '{'0, 7'd2, 7'd127, 7'($urandom_range(3, 126)), '0};
        foreach (offsets[i]) begin
            settle();
            write_column_offset(offsets[i]);
            run_bus_traffic(375);
        end
    endtask

    initial begin
        foreach (pix_mem[i]) pix_mem[i] = 8'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_up();
        test_display_commands();
        test_horizontal_wrap();
        test_offset_phases();
        settle();

        $display("%0d input beats, %0d result beats checked, %0d errors", beats_sent,
                 results_checked, error_count);
        $display("covered commands, pixel writes and reads, column offsets 0, 2 and 127");
        if (error_count == 0) begin
            $display("oled_command_and_pixel_ram_core: match");
        end else begin
            $display("oled_command_and_pixel_ram_core: mismatch");
        end
        $finish;
    end

endmodule
